// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the trimmer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("property violated");
// Condition must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

// ===== hw/rtl/prqt_pkg.sv =====
// Types and constants of the paired read quality trimmer.
package prqt_pkg;

   localparam int MAX_READ_LEN_DEFAULT = 4096;
   localparam int LEN_W   = 13;
   localparam int SCORE_W = 7;
   localparam int QUAL_W  = 8;

   localparam logic [QUAL_W-1:0] PHRED_OFFSET = 8'd33;

   // Register reset values
   localparam logic [SCORE_W-1:0] LOW_QUALITY_SCORE_RST   = 7'd20;
   localparam logic [LEN_W-1:0]   MAX_LOW_BASES_RST       = 13'd3;
   localparam logic [LEN_W-1:0]   MAX_CONSECUTIVE_LOW_RST = 13'd3;
   localparam logic [LEN_W-1:0]   MIN_KEPT_LENGTH_RST     = 13'd75;

   typedef enum logic [1:0] {
      CSR_LOW_QUALITY_SCORE   = 2'd0,
      CSR_MAX_LOW_BASES       = 2'd1,
      CSR_MAX_CONSECUTIVE_LOW = 2'd2,
      CSR_MIN_KEPT_LENGTH     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [SCORE_W-1:0] low_quality_score;
      logic [LEN_W-1:0]   max_low_bases;
      logic [LEN_W-1:0]   max_consecutive_low;
      logic [LEN_W-1:0]   min_kept_length;
   } cfg_type;

   typedef struct packed {
      logic             mate_index;
      logic [LEN_W-1:0] trimmed_length;
      logic             pair_keep;
   } rsp_word_type;

endpackage

// ===== hw/rtl/prqt_req_if.sv =====
// Input channel: one quality byte per word.
interface prqt_req_if;
   import prqt_pkg::*;

   logic              valid;
   logic              ready;
   logic [QUAL_W-1:0] quality_char;
   logic              end_of_read;

   modport source (output valid, output quality_char, output end_of_read, input ready);
   modport sink (input valid, input quality_char, input end_of_read, output ready);
endinterface

// ===== hw/rtl/prqt_rsp_if.sv =====
// Result channel: one trimmed length per read.
interface prqt_rsp_if;
   import prqt_pkg::*;

   logic             valid;
   logic             ready;
   logic             mate_index;
   logic [LEN_W-1:0] trimmed_length;
   logic             pair_keep;

   modport source (output valid, output mate_index, output trimmed_length,
                   output pair_keep, input ready);
   modport sink (input valid, input mate_index, input trimmed_length,
                 input pair_keep, output ready);
endinterface

// ===== hw/rtl/paired_read_quality_trimmer.sv =====
// Paired read quality trimmer: top level with register port and result buffering.
//
// Usage: quality bytes (phred + 33) stream in on req_chan, one base per word,
// mate 0 first, then mate 1; end_of_read marks the last base of each read.
// A word with end_of_read set yields one result word on rsp_chan: the mate
// index, the trimmed length (0 = discarded) and, on mate 1, the pair verdict.
// Other words yield nothing.
// A result is registered into the output register, or into the skid register
// on a stall. One byte per cycle is taken while the skid register is empty;
// each byte's update is saturating counters and compares in the accept cycle.
// The user writes registers through csr_write_enable / csr_index / csr_write_data
// while the block is idle (not enforced); they take effect on the next byte.
// Reset (synchronous, active high) loads the register defaults and starts
// at mate 0 with a clear read. If the receiver stalls, one result waits in
// the output register and a second in a skid register; req_chan.ready drops
// only while the skid register is full.
`include "assert_macros.svh"

module paired_read_quality_trimmer #(
   parameter int MAX_READ_LEN = prqt_pkg::MAX_READ_LEN_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   prqt_req_if.sink                    req_chan,
   prqt_rsp_if.source                  rsp_chan,
   input  logic                        csr_write_enable,
   input  prqt_pkg::csr_index_type     csr_index,
   input  logic [prqt_pkg::LEN_W-1:0]  csr_write_data
);
   import prqt_pkg::*;

   cfg_type      cfg_ff;
   logic         req_fire;
   logic         result_valid;
   rsp_word_type result_word;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_word_type skid_word_ff, skid_word_in;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_quality_score   <= LOW_QUALITY_SCORE_RST;
         cfg_ff.max_low_bases       <= MAX_LOW_BASES_RST;
         cfg_ff.max_consecutive_low <= MAX_CONSECUTIVE_LOW_RST;
         cfg_ff.min_kept_length     <= MIN_KEPT_LENGTH_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_LOW_QUALITY_SCORE: begin
               cfg_ff.low_quality_score <= csr_write_data[SCORE_W-1:0];
            end
            CSR_MAX_LOW_BASES: begin
               cfg_ff.max_low_bases <= csr_write_data;
            end
            CSR_MAX_CONSECUTIVE_LOW: begin
               cfg_ff.max_consecutive_low <= csr_write_data;
            end
            CSR_MIN_KEPT_LENGTH: begin
               cfg_ff.min_kept_length <= csr_write_data;
            end
            default: begin
            end
         endcase
      end
   end

   // Accept a word unless the skid register is occupied
   assign req_chan.ready = !skid_valid_ff;
   assign req_fire       = req_chan.valid && !skid_valid_ff;

   prqt_core #(
      .MAX_READ_LEN (MAX_READ_LEN)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .item_fire    (req_fire),
      .quality_char (req_chan.quality_char),
      .end_of_read  (req_chan.end_of_read),
      .cfg          (cfg_ff),
      .result_valid (result_valid),
      .result_word  (result_word)
   );

   // Steer results into the output register, or the skid register on a stall
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_word_in   = rsp_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      if (!rsp_valid_ff || rsp_chan.ready) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_word_in   = skid_word_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = result_valid;
            rsp_word_in  = result_word;
         end
      end else if (result_valid) begin
         skid_valid_in = 1'b1;
         skid_word_in  = result_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      rsp_word_ff  <= rsp_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.mate_index     = rsp_word_ff.mate_index;
   assign rsp_chan.trimmed_length = rsp_word_ff.trimmed_length;
   assign rsp_chan.pair_keep      = rsp_word_ff.pair_keep;

   `ASSERT_NEVER(skid_without_output, clock, reset, skid_valid_ff && !rsp_valid_ff)
   `ASSERT_ALWAYS(read_end_gives_result, clock, reset, (req_fire && req_chan.end_of_read) |=> rsp_valid_ff)
   `ASSERT_ALWAYS(skid_fills_on_stall, clock, reset, $rose(skid_valid_ff) |-> $past(rsp_valid_ff && !rsp_chan.ready))

endmodule

// ===== hw/rtl/prqt_core.sv =====
// Per-read trimming state and the single-pass update for one quality byte.
`include "assert_macros.svh"

module prqt_core #(
   parameter int MAX_READ_LEN = prqt_pkg::MAX_READ_LEN_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_fire,
   input  logic [7:0]            quality_char,
   input  logic                  end_of_read,
   input  prqt_pkg::cfg_type     cfg,
   output logic                  result_valid,
   output prqt_pkg::rsp_word_type result_word
);
   import prqt_pkg::*;

   localparam int CNT_W = $clog2(MAX_READ_LEN + 1);
   localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_READ_LEN);

   logic             mate_ff, mate_in;
   logic [CNT_W-1:0] base_position_ff, base_position_in;
   logic [CNT_W-1:0] low_total_ff, low_total_in;
   logic [CNT_W-1:0] low_run_ff, low_run_in;
   logic             length_decided_ff, length_decided_in;
   logic [CNT_W-1:0] decided_length_ff, decided_length_in;
   logic [CNT_W-1:0] first_mate_length_ff, first_mate_length_in;

   logic [QUAL_W-1:0] threshold;
   logic              is_low;
   logic [CNT_W-1:0]  run_sat, total_sat, pos_sat;
   logic [CNT_W:0]    pos_plus1, run_ext;
   logic [CNT_W-1:0]  cut_len;
   logic              run_hit, total_over;
   logic [CNT_W-1:0]  read_len;
   logic              keep;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v >= CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
   endfunction

   // Classify the byte and form the candidate counts
   assign threshold  = {1'b0, cfg.low_quality_score} + PHRED_OFFSET;
   assign is_low     = quality_char < threshold;
   assign run_sat    = sat_inc(low_run_ff);
   assign total_sat  = sat_inc(low_total_ff);
   assign pos_sat    = sat_inc(base_position_ff);
   assign pos_plus1  = (CNT_W+1)'(base_position_ff) + (CNT_W+1)'(1);
   assign run_ext    = (CNT_W+1)'(run_sat);
   assign cut_len    = (pos_plus1 >= run_ext) ? CNT_W'(pos_plus1 - run_ext) : '0;
   assign run_hit    = (cfg.max_consecutive_low != '0) &&
                       (CMP_W'(run_sat) == CMP_W'(cfg.max_consecutive_low));
   assign total_over = CMP_W'(total_sat) > CMP_W'(cfg.max_low_bases);

   // Advance the read state; emit and clear at the read end
   always_comb begin
      mate_in              = mate_ff;
      base_position_in     = base_position_ff;
      low_total_in         = low_total_ff;
      low_run_in           = low_run_ff;
      length_decided_in    = length_decided_ff;
      decided_length_in    = decided_length_ff;
      first_mate_length_in = first_mate_length_ff;
      read_len             = '0;
      keep                 = 1'b0;

      if (item_fire && !length_decided_ff) begin
         if (is_low) begin
            low_run_in   = run_sat;
            low_total_in = total_sat;
            if (run_hit) begin
               length_decided_in = 1'b1;
               decided_length_in = cut_len;
            end else if (total_over) begin
               length_decided_in = 1'b1;
               decided_length_in = '0;
            end
         end else begin
            low_run_in = '0;
         end
         base_position_in = pos_sat;
      end

      read_len = length_decided_in ? decided_length_in : base_position_in;
      keep = (first_mate_length_ff != '0) && (read_len != '0) &&
             (CMP_W'(first_mate_length_ff) >= CMP_W'(cfg.min_kept_length)) &&
             (CMP_W'(read_len) >= CMP_W'(cfg.min_kept_length));

      if (item_fire && end_of_read) begin
         if (!mate_ff) begin
            first_mate_length_in = read_len;
         end
         mate_in           = ~mate_ff;
         base_position_in  = '0;
         low_total_in      = '0;
         low_run_in        = '0;
         length_decided_in = 1'b0;
         decided_length_in = '0;
      end
   end

   assign result_valid               = item_fire && end_of_read;
   assign result_word.mate_index     = mate_ff;
   assign result_word.trimmed_length = LEN_W'(read_len);
   assign result_word.pair_keep      = mate_ff && keep;

   // Hold the read state
   always_ff @(posedge clock) begin
      if (reset) begin
         mate_ff              <= 1'b0;
         base_position_ff     <= '0;
         low_total_ff         <= '0;
         low_run_ff           <= '0;
         length_decided_ff    <= 1'b0;
         decided_length_ff    <= '0;
         first_mate_length_ff <= '0;
      end else begin
         mate_ff              <= mate_in;
         base_position_ff     <= base_position_in;
         low_total_ff         <= low_total_in;
         low_run_ff           <= low_run_in;
         length_decided_ff    <= length_decided_in;
         decided_length_ff    <= decided_length_in;
         first_mate_length_ff <= first_mate_length_in;
      end
   end

   `ASSERT_NEVER(run_above_position, clock, reset, low_run_ff > base_position_ff)
   `ASSERT_NEVER(total_below_run, clock, reset, low_total_ff < low_run_ff)
   `ASSERT_NEVER(cut_past_position, clock, reset, length_decided_ff && (decided_length_ff > base_position_ff))

endmodule

// ===== tb/paired_read_quality_trimmer_test.sv =====
// Testbench for the paired read quality trimmer: predicts each trimmed length and checks it.
`timescale 1ns / 100ps

module paired_read_quality_trimmer_test;
   import prqt_pkg::*;

   localparam int READ_LEN_CAP   = MAX_READ_LEN_DEFAULT;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 4;

   typedef logic [QUAL_W-1:0] qual_list_type[$];

   logic clock;
   logic reset;
   logic                csr_write_enable;
   csr_index_type       csr_index;
   logic [LEN_W-1:0]    csr_write_data;

   prqt_req_if req_chan ();
   prqt_rsp_if rsp_chan ();

   paired_read_quality_trimmer u_top (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Register copies held by the predictor
   logic [SCORE_W-1:0] cfg_score;
   logic [LEN_W-1:0]   cfg_low_limit;
   logic [LEN_W-1:0]   cfg_run_limit;
   logic [LEN_W-1:0]   cfg_min_length;

   // Per-read and per-pair trimming state
   bit read_mate;
   int base_count;
   int low_count;
   int run_count;
   bit length_fixed;
   int fixed_length;
   int mate0_length;

   rsp_word_type expected_lengths[$];

   int error_count;
   int words_sent;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_left;
   int idle_cycles;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int count_up(input int value);
      return (value >= READ_LEN_CAP) ? READ_LEN_CAP : value + 1;
   endfunction

   // Advance the trimming state by one base; queue a result at each read end
   task automatic predict_trim(input logic [QUAL_W-1:0] qual, input logic last_base);
      int len;
      bit keep;
      rsp_word_type word;
      if (!length_fixed) begin
         if (int'(qual) < int'(cfg_score) + int'(PHRED_OFFSET)) begin
            run_count = count_up(run_count);
            low_count = count_up(low_count);
            if (cfg_run_limit != 0 && run_count == int'(cfg_run_limit)) begin
               length_fixed = 1'b1;
               fixed_length = (base_count + 1 >= run_count) ? base_count + 1 - run_count : 0;
            end else if (low_count > int'(cfg_low_limit)) begin
               length_fixed = 1'b1;
               fixed_length = 0;
            end
         end else begin
            run_count = 0;
         end
         base_count = count_up(base_count);
      end
      if (last_base) begin
         len = length_fixed ? fixed_length : base_count;
         keep = 1'b0;
         if (read_mate) begin
            keep = mate0_length != 0 && len != 0 &&
                   mate0_length >= int'(cfg_min_length) && len >= int'(cfg_min_length);
         end else begin
            mate0_length = len;
         end
         word.mate_index     = read_mate;
         word.trimmed_length = len[LEN_W-1:0];
         word.pair_keep      = keep;
         expected_lengths.push_back(word);
         read_mate    = ~read_mate;
         base_count   = 0;
         low_count    = 0;
         run_count    = 0;
         length_fixed = 1'b0;
         fixed_length = 0;
      end
   endtask

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      error_count++;
   endtask

   // Offer one word, idling at random first; predict once it is taken
   task automatic send_base(input logic [QUAL_W-1:0] qual, input logic last_base);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.quality_char <= qual;
      req_chan.end_of_read  <= last_base;
      do @(posedge clock); while (!req_chan.ready);
      predict_trim(qual, last_base);
      words_sent++;
   endtask

   task automatic send_qualities(input qual_list_type quals);
      foreach (quals[i]) send_base(quals[i], i == quals.size() - 1);
   endtask

   task automatic send_read(input int len, input int lo, input int hi);
      for (int i = 0; i < len; i++) send_base(QUAL_W'($urandom_range(hi, lo)), i == len - 1);
   endtask

   // Drop valid and wait until every result has come back
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (expected_lengths.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all four registers back to back; block must be idle
   task automatic set_config(input logic [SCORE_W-1:0] score, input logic [LEN_W-1:0] low_lim,
                             input logic [LEN_W-1:0] run_lim, input logic [LEN_W-1:0] min_len);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_LOW_QUALITY_SCORE;
      csr_write_data   <= LEN_W'(score);
      @(posedge clock);
      csr_index      <= CSR_MAX_LOW_BASES;
      csr_write_data <= low_lim;
      @(posedge clock);
      csr_index      <= CSR_MAX_CONSECUTIVE_LOW;
      csr_write_data <= run_lim;
      @(posedge clock);
      csr_index      <= CSR_MIN_KEPT_LENGTH;
      csr_write_data <= min_len;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_score      = score;
      cfg_low_limit  = low_lim;
      cfg_run_limit  = run_lim;
      cfg_min_length = min_len;
   endtask

   function automatic logic [LEN_W-1:0] pick_limit(input int hi);
      case ($urandom_range(7))
         0: return '0;
         1: return LEN_W'(READ_LEN_CAP);
         default: return LEN_W'($urandom_range(hi, 0));
      endcase
   endfunction

   // One read with random length and a random share of low bases
   task automatic send_random_read();
      int len;
      int low_pct;
      int thr;
      bit noise;
      logic [QUAL_W-1:0] qual;
      len = ($urandom_range(9) < 2) ? $urandom_range(100, 50) : $urandom_range(25, 1);
      noise = ($urandom_range(9) == 0);
      case ($urandom_range(3))
         0: low_pct = 0;
         1: low_pct = 10;
         2: low_pct = 30;
         default: low_pct = 70;
      endcase
      thr = int'(cfg_score) + int'(PHRED_OFFSET);
      for (int i = 0; i < len; i++) begin
         if (noise)
            qual = QUAL_W'($urandom_range(255, 0));
         else if ($urandom_range(99) < low_pct)
            qual = QUAL_W'($urandom_range(thr - 1, 0));
         else
            qual = QUAL_W'($urandom_range(255, thr));
         send_base(qual, i == len - 1);
      end
   endtask

   // Default registers: boundary bytes, run cut, discard, cut beating discard
   task automatic test_default_trim_rules();
      send_qualities('{8'd255});
      send_qualities('{8'd0});
      send_qualities('{8'd60, 8'd10, 8'd10, 8'd10, 8'd255});
      send_qualities('{8'd10, 8'd53, 8'd10, 8'd53, 8'd10, 8'd52});
      send_qualities('{8'd10, 8'd60, 8'd10, 8'd10, 8'd10});
      send_qualities('{8'd126, 8'd127});
      settle();
   endtask

   // Run limit off, zero low budget, small minimum so a pair can be kept
   task automatic test_run_limit_off();
      set_config(7'd0, 13'd0, 13'd0, 13'd2);
      send_qualities('{8'd33, 8'd34});
      send_qualities('{8'd40, 8'd32});
      send_qualities('{8'd33, 8'd33});
      send_qualities('{8'd200, 8'd201});
      settle();
   endtask

   // Random pairs, new register setting every few pairs
   task automatic test_random_pairs(input int n_words);
      int goal;
      goal = words_sent + n_words;
      while (words_sent < goal) begin
         settle();
         case ($urandom_range(3))
            0: set_config(7'd0, pick_limit(20), pick_limit(8), pick_limit(40));
            1: set_config(7'd93, pick_limit(20), pick_limit(8), pick_limit(40));
            default: set_config(SCORE_W'($urandom_range(93, 0)), pick_limit(20),
                                pick_limit(8), pick_limit(40));
         endcase
         repeat (8) send_random_read();
      end
      settle();
   endtask

   // Hold the receiver off while single-base reads keep coming
   task automatic test_output_stall();
      hold_left = 200;
      repeat (20) send_read(1, 0, 255);
      settle();
   endtask

   // Receiver: long hold when asked, otherwise random stalls
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_lengths.size() == 0) begin
            report_mismatch($sformatf("unexpected result mate %0d length %0d keep %0d",
                                      rsp_chan.mate_index, rsp_chan.trimmed_length,
                                      rsp_chan.pair_keep));
         end else begin
            want = expected_lengths.pop_front();
            if (rsp_chan.mate_index !== want.mate_index)
               report_mismatch($sformatf("mate_index got %0d want %0d",
                                         rsp_chan.mate_index, want.mate_index));
            if (rsp_chan.trimmed_length !== want.trimmed_length)
               report_mismatch($sformatf("trimmed_length got %0d want %0d",
                                         rsp_chan.trimmed_length, want.trimmed_length));
            if (rsp_chan.pair_keep !== want.pair_keep)
               report_mismatch($sformatf("pair_keep got %0d want %0d",
                                         rsp_chan.pair_keep, want.pair_keep));
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles = 0;
      else
         idle_cycles = idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      reset                 = 1'b1;
      csr_write_enable      = 1'b0;
      csr_index             = CSR_LOW_QUALITY_SCORE;
      csr_write_data        = '0;
      req_chan.valid        = 1'b0;
      req_chan.quality_char = '0;
      req_chan.end_of_read  = 1'b0;
      rsp_chan.ready        = 1'b0;
      error_count  = 0;
      words_sent   = 0;
      hold_left    = 0;
      idle_cycles  = 0;
      cfg_score      = LOW_QUALITY_SCORE_RST;
      cfg_low_limit  = MAX_LOW_BASES_RST;
      cfg_run_limit  = MAX_CONSECUTIVE_LOW_RST;
      cfg_min_length = MIN_KEPT_LENGTH_RST;
      read_mate    = 1'b0;
      base_count   = 0;
      low_count    = 0;
      run_count    = 0;
      length_fixed = 1'b0;
      fixed_length = 0;
      mate0_length = 0;
      send_idle_pct = 38;
      recv_idle_pct = 87;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_trim_rules();
      test_run_limit_off();
      test_random_pairs(380);

      send_idle_pct = 87;
      recv_idle_pct = 38;
      test_random_pairs(380);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_pairs(390);
      test_output_stall();

      settle();
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
